// ===== src/tick_task_scheduler_table_assert.svh =====
// Assertion macros for the task scheduler table.
`ifndef TICK_TASK_SCHEDULER_TABLE_ASSERT_SVH
`define TICK_TASK_SCHEDULER_TABLE_ASSERT_SVH

// If a holds at a clock edge, c must hold at that same edge.
`define TTS_ASSERT_SAME(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("tts check failed");

// If a holds at a clock edge, c must hold at the next edge.
`define TTS_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("tts check failed");

`endif

// ===== src/tts_pkg.sv =====
`default_nettype none
package tts_pkg;

   localparam int MaxTasksDefault = 8;
   localparam int ResultCap       = 8;
   localparam int CntW            = 4;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ADD      = 2'd1,
      OP_DELETE   = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ADD  = 2'd0,
      KIND_DEL  = 2'd1,
      KIND_RUN  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_FULL   = 2'd1,
      ERR_DELETE = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_TICK,
      B_ADD,
      B_DISP,
      B_FLUSH
   } back_state_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] delay;
      logic [31:0] period;
      logic [7:0]  tag;
      logic [2:0]  sel;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage
`default_nettype wire

// ===== src/tick_task_scheduler_table.sv =====
`default_nettype none
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+----------------------------
// request   | req_mode, req_task_delay,               | word taken when start && !busy
//           | req_task_period, req_task_tag,          |
//           | req_slot_select                         |
// response  | rsp_result_kind, rsp_slot, rsp_tag_out, | one word per rsp_strobe cycle
//           | rsp_error_code, rsp_last                |
//
// Table walk: the back end walks the table one slot per cycle. A tick visits
//   every slot, an add stops at the first free slot, a delete touches only its
//   selected slot, a dispatch stops at the last slot or after the eighth pending slot.
// Responses appear one register stage after the back end produces them.
// A two-word command queue sits between front and back; busy is high while it
// is full. The receiver cannot stall: each word is valid for one cycle only.
// Reset is synchronous, active high; it frees every slot at once.
module tick_task_scheduler_table #(
   parameter int MAX_TASKS = tts_pkg::MaxTasksDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_task_delay,
   input  wire logic [31:0] req_task_period,
   input  wire logic [7:0]  req_task_tag,
   input  wire logic [2:0]  req_slot_select,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_result_kind,
   output logic [3:0]       rsp_slot,
   output logic [7:0]       rsp_tag_out,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last
);
   import tts_pkg::*;

   `include "tick_task_scheduler_table_assert.svh"

   queue_out_type q_out;
   logic          q_pop;

   // check terms
   logic chk_single, chk_none, chk_pop_del, chk_del_word;

   // front: accepts and classifies request words into the queue
   tts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_task_delay  (req_task_delay),
      .req_task_period (req_task_period),
      .req_task_tag    (req_task_tag),
      .req_slot_select (req_slot_select),
      .q_out           (q_out),
      .q_pop           (q_pop)
   );

   // back: owns the table and walks it per command
   tts_back #(
      .MAX_TASKS (MAX_TASKS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_out           (q_out),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_kind (rsp_result_kind),
      .rsp_slot        (rsp_slot),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last)
   );

   assign chk_single   = rsp_strobe && (rsp_result_kind != KIND_RUN);
   assign chk_none     = rsp_strobe && (rsp_result_kind == KIND_NONE);
   assign chk_pop_del  = q_pop && (q_out.cmd.op == OP_DELETE);
   assign chk_del_word = rsp_strobe && (rsp_result_kind == KIND_DEL);

   // single-word answers always close their command
   `TTS_ASSERT_SAME(a_single_last, clock, reset, chk_single, rsp_last)
   // nothing found reports slot zero
   `TTS_ASSERT_SAME(a_none_slot, clock, reset, chk_none, rsp_slot == 4'd0)
   // a pop only happens with a queued command
   `TTS_ASSERT_SAME(a_pop_valid, clock, reset, q_pop, q_out.valid)
   // a delete answers in the cycle right after it leaves the queue
   `TTS_ASSERT_NEXT(a_del_answer, clock, reset, chk_pop_del, chk_del_word)

endmodule
`default_nettype wire

// ===== src/tts_front.sv =====
`default_nettype none
module tts_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_mode,
   input  wire logic [31:0]           req_task_delay,
   input  wire logic [31:0]           req_task_period,
   input  wire logic [7:0]            req_task_tag,
   input  wire logic [2:0]            req_slot_select,
   output tts_pkg::queue_out_type     q_out,
   input  wire logic                  q_pop
);
   import tts_pkg::*;

   // two-entry command queue
   cmd_type    q_mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    cmd_new;

   always_comb begin
      cmd_new.op     = op_type'(req_mode);
      cmd_new.delay  = req_task_delay;
      cmd_new.period = req_task_period;
      cmd_new.tag    = req_task_tag;
      cmd_new.sel    = req_slot_select;
   end

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.cmd   = q_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule
`default_nettype wire

// ===== src/tts_back.sv =====
`default_nettype none
module tts_back #(
   parameter int MAX_TASKS = tts_pkg::MaxTasksDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tts_pkg::queue_out_type q_out,
   output logic                       q_pop,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_result_kind,
   output logic [3:0]                 rsp_slot,
   output logic [7:0]                 rsp_tag_out,
   output logic [1:0]                 rsp_error_code,
   output logic                       rsp_last
);
   import tts_pkg::*;

   localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_TASKS - 1);

   // task table; only busy bits need reset, a free slot never reads the rest
   logic        busy_ff [MAX_TASKS];
   logic [7:0]  tag_mem [MAX_TASKS];
   logic [31:0] dly_mem [MAX_TASKS];
   logic [31:0] per_mem [MAX_TASKS];
   logic [7:0]  pnd_mem [MAX_TASKS];

   back_state_type  state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            held_v_ff, held_v_in;
   logic [IdxW-1:0] held_slot_ff, held_slot_in;
   logic [7:0]      held_tag_ff, held_tag_in;
   logic [1:0]      err_ff, err_in;
   cmd_type         cur_ff, cur_in;

   logic            rv_ff, rv_in;
   logic [1:0]      rkind_ff, rkind_in;
   logic [3:0]      rslot_ff, rslot_in;
   logic [7:0]      rtag_ff, rtag_in;
   logic            rlast_ff, rlast_in;

   // single table write port
   logic            we;
   logic [IdxW-1:0] widx, ridx;
   logic            w_busy;
   logic [7:0]      w_tag, w_pnd;
   logic [31:0]     w_dly, w_per;
   logic            r_busy;
   logic [7:0]      r_tag, r_pnd;
   logic [31:0]     r_dly, r_per;
   logic            sel_ok;

   assign sel_ok = (32'(q_out.cmd.sel) < 32'(MAX_TASKS));
   assign ridx   = (state_ff == B_IDLE) ? IdxW'(q_out.cmd.sel) : idx_ff;
   assign r_busy = busy_ff[ridx];
   assign r_tag  = tag_mem[ridx];
   assign r_dly  = dly_mem[ridx];
   assign r_per  = per_mem[ridx];
   assign r_pnd  = pnd_mem[ridx];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      held_v_in    = held_v_ff;
      held_slot_in = held_slot_ff;
      held_tag_in  = held_tag_ff;
      err_in       = err_ff;
      cur_in       = cur_ff;
      q_pop        = 1'b0;
      rv_in        = 1'b0;
      rkind_in     = rkind_ff;
      rslot_in     = rslot_ff;
      rtag_in      = rtag_ff;
      rlast_in     = rlast_ff;
      we           = 1'b0;
      widx         = ridx;
      w_busy       = r_busy;
      w_tag        = r_tag;
      w_dly        = r_dly;
      w_per        = r_per;
      w_pnd        = r_pnd;
      case (state_ff)
         B_IDLE: begin
            if (q_out.valid) begin
               q_pop  = 1'b1;
               cur_in = q_out.cmd;
               idx_in = '0;
               case (q_out.cmd.op)
                  OP_TICK:  state_in = B_TICK;
                  OP_ADD:   state_in = B_ADD;
                  OP_DELETE: begin
                     if (!sel_ok || !r_busy) begin
                        err_in = ERR_DELETE;
                     end
                     if (sel_ok) begin
                        we     = 1'b1;
                        w_busy = 1'b0;
                        w_pnd  = 8'd0;
                     end
                     rv_in    = 1'b1;
                     rkind_in = KIND_DEL;
                     rslot_in = {1'b0, q_out.cmd.sel};
                     rtag_in  = 8'd0;
                     rlast_in = 1'b1;
                  end
                  default: begin
                     cnt_in    = '0;
                     held_v_in = 1'b0;
                     state_in  = B_DISP;
                  end
               endcase
            end
         end
         B_TICK: begin
            if (r_busy) begin
               we = 1'b1;
               if (r_dly == 32'd0) begin
                  if (r_pnd != 8'hFF) begin
                     w_pnd = r_pnd + 8'd1;
                  end
                  if (r_per != 32'd0) begin
                     w_dly = r_per;
                  end
               end else begin
                  w_dly = r_dly - 32'd1;
               end
            end
            if (idx_ff == LastIdx) begin
               state_in = B_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         B_ADD: begin
            if (!r_busy) begin
               we       = 1'b1;
               w_busy   = 1'b1;
               w_tag    = cur_ff.tag;
               w_dly    = cur_ff.delay;
               w_per    = cur_ff.period;
               w_pnd    = 8'd0;
               rv_in    = 1'b1;
               rkind_in = KIND_ADD;
               rslot_in = 4'(idx_ff);
               rtag_in  = 8'd0;
               rlast_in = 1'b1;
               state_in = B_IDLE;
            end else if (idx_ff == LastIdx) begin
               err_in   = ERR_FULL;
               rv_in    = 1'b1;
               rkind_in = KIND_ADD;
               rslot_in = 4'(MAX_TASKS);
               rtag_in  = 8'd0;
               rlast_in = 1'b1;
               state_in = B_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         B_DISP: begin
            if (r_busy && (r_pnd != 8'd0)) begin
               // the previous find is not last: a later one exists
               if (held_v_ff) begin
                  rv_in    = 1'b1;
                  rkind_in = KIND_RUN;
                  rslot_in = 4'(held_slot_ff);
                  rtag_in  = held_tag_ff;
                  rlast_in = 1'b0;
               end
               held_v_in    = 1'b1;
               held_slot_in = idx_ff;
               held_tag_in  = r_tag;
               cnt_in       = cnt_ff + 1'b1;
               we           = 1'b1;
               w_pnd        = r_pnd - 8'd1;
               if (r_per == 32'd0) begin
                  w_busy = 1'b0;
                  w_pnd  = 8'd0;
               end
               if ((cnt_in == CntW'(ResultCap)) || (idx_ff == LastIdx)) begin
                  state_in = B_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (idx_ff == LastIdx) begin
               state_in = B_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         B_FLUSH: begin
            rv_in    = 1'b1;
            rlast_in = 1'b1;
            if (held_v_ff) begin
               rkind_in = KIND_RUN;
               rslot_in = 4'(held_slot_ff);
               rtag_in  = held_tag_ff;
            end else begin
               rkind_in = KIND_NONE;
               rslot_in = 4'd0;
               rtag_in  = 8'd0;
            end
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         err_ff    <= ERR_NONE;
         rv_ff     <= 1'b0;
         held_v_ff <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            busy_ff[i] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         err_ff    <= err_in;
         rv_ff     <= rv_in;
         held_v_ff <= held_v_in;
         if (we) begin
            busy_ff[widx] <= w_busy;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      held_slot_ff <= held_slot_in;
      held_tag_ff  <= held_tag_in;
      cur_ff       <= cur_in;
      rkind_ff     <= rkind_in;
      rslot_ff     <= rslot_in;
      rtag_ff      <= rtag_in;
      rlast_ff     <= rlast_in;
      if (we) begin
         tag_mem[widx] <= w_tag;
         dly_mem[widx] <= w_dly;
         per_mem[widx] <= w_per;
         pnd_mem[widx] <= w_pnd;
      end
   end

   assign rsp_strobe      = rv_ff;
   assign rsp_result_kind = rkind_ff;
   assign rsp_slot        = rslot_ff;
   assign rsp_tag_out     = rtag_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_last        = rlast_ff;

endmodule
`default_nettype wire
